FILE: design/sls_pkg.sv
package sls_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int ID_W            = 64;
    localparam int SEED_W          = 32;
    localparam int SEED_SHIFT      = 32;
    localparam int SH_A            = 12;
    localparam int SH_B            = 25;
    localparam int SH_C            = 27;
    localparam int MUL_BITS        = 64;
    localparam int MUL_CNT_W       = 6;

    localparam logic [ID_W-1:0] MIX_MUL = 64'h2545_F491_4F6C_DD1D;

    typedef struct packed {
        logic [ID_W-1:0]   entry_id;
        logic [SEED_W-1:0] seed_seconds;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [ID_W-1:0] shuffled_id;
        logic            final_entry;
    } result_t;

    // control from the sequencer to the draw unit
    typedef struct packed {
        logic load;   // take a new seed, counter back to zero
        logic go;     // begin one draw
        logic next;   // step the counter on by one index
    } draw_ctrl_t;

endpackage

FILE: design/sls_draw.sv
module sls_draw #(
    parameter int MAX_ENTRIES = sls_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sls_pkg::draw_ctrl_t              ctrl,
    input  logic [sls_pkg::SEED_W-1:0]       seed,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] span,
    output logic                             done,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] rem
);
    import sls_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // counter value: seed_hi + i * C, advanced by one add per index
    logic [ID_W-1:0]      x_reg, x_next;
    logic [ID_W-1:0]      k_reg, k_next;      // mixed draw, shifted out LSB first
    logic [ID_W-1:0]      p_reg, p_next;      // multiplier partial sum
    logic [CNT_W-1:0]     r_reg, r_next;      // running remainder
    logic [CNT_W-1:0]     w_reg, w_next;      // 2^b mod span
    logic [CNT_W-1:0]     span_reg, span_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;

    logic [ID_W:0]        sum;
    logic                 pbit;

    function automatic logic [ID_W-1:0] xorshift(input logic [ID_W-1:0] v);
        logic [ID_W-1:0] t;
        t = v ^ (v >> SH_A);
        t = t ^ (t << SH_B);
        t = t ^ (t >> SH_C);
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] add_mod(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b,
                                                 input logic [CNT_W-1:0] m);
        logic [CNT_W:0] t;
        t = {1'b0, a} + {1'b0, b};
        if (t >= {1'b0, m})
            t = t - {1'b0, m};
        return t[CNT_W-1:0];
    endfunction

    // product bits come out LSB first and fold straight into the remainder
    assign sum  = {1'b0, p_reg} + (k_reg[0] ? {1'b0, MIX_MUL} : '0);
    assign pbit = sum[0];

    always_comb
    begin
        x_next    = x_reg;
        k_next    = k_reg;
        p_next    = p_reg;
        r_next    = r_reg;
        w_next    = w_reg;
        span_next = span_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (ctrl.load)
            x_next = {seed, {SEED_SHIFT{1'b0}}};
        else if (ctrl.next)
            x_next = x_reg + MIX_MUL;

        if (ctrl.go)
        begin
            k_next    = xorshift(x_reg);
            p_next    = '0;
            r_next    = '0;
            w_next    = (span != CNT_W'(1)) ? CNT_W'(1) : '0;
            span_next = span;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            k_next   = k_reg >> 1;
            p_next   = sum[ID_W:1];
            if (pbit)
                r_next = add_mod(r_reg, w_reg, span_reg);
            w_next   = add_mod(w_reg, w_reg, span_reg);
            cnt_next = cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(MUL_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        r_reg    <= r_next;
        w_reg    <= w_next;
        span_reg <= span_next;
    end

    assign done = done_reg;
    assign rem  = r_reg;

endmodule

FILE: design/seeded_list_shuffle.sv
// Seeded list shuffle. Entries are loaded one beat per cycle (start high, busy low);
// a beat arriving while MAX_ENTRIES entries are held is dropped. The beat marked last
// also carries the 32-bit seed and starts a Fisher-Yates pass over the n held entries.
// Each swap step is paced by the bit-serial 64-bit multiply that feeds the remainder unit
// one product bit per cycle; after the pass the n results follow one per cycle on strobe,
// final_entry marking the last. busy is high from the last beat until the final read is
// issued; results cannot be stalled.
module seeded_list_shuffle #(
    parameter int MAX_ENTRIES = sls_pkg::MAX_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  sls_pkg::item_t   item,
    output logic             strobe,
    output sls_pkg::result_t result
);
    import sls_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MIX    = 7'b0000010,
        ST_DRAW   = 7'b0000100,
        ST_READ   = 7'b0001000,
        ST_SWAP_I = 7'b0010000,
        ST_SWAP_J = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic             strobe_reg, strobe_next;
    logic             final_reg, final_next;

    logic [ID_W-1:0]  mem [MAX_ENTRIES];
    logic [ID_W-1:0]  rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic [ID_W-1:0]  wr_data;
    logic             wr_en;

    draw_ctrl_t       dctrl;
    logic             draw_done;
    logic [CNT_W-1:0] draw_rem;
    logic [CNT_W-1:0] span;

    logic             accept;
    logic             full;
    logic [CNT_W-1:0] i_inc;

    assign accept = start && (state_reg == ST_IDLE);
    assign full   = (count_reg == MAX_CNT);
    assign i_inc  = i_reg + CNT_W'(1);
    assign span   = n_reg - i_reg;

    sls_draw #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_draw (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (dctrl),
        .seed (item.seed_seconds),
        .span (span),
        .done (draw_done),
        .rem  (draw_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        strobe_next = 1'b0;
        final_next  = 1'b0;
        dctrl       = '0;
        wr_en       = 1'b0;
        wr_addr     = count_reg[IDX_W-1:0];
        wr_data     = item.entry_id;
        rd_addr_a   = i_reg[IDX_W-1:0];
        rd_addr_b   = j_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (item.last)
                    begin
                        n_next     = full ? count_reg : count_reg + CNT_W'(1);
                        i_next     = '0;
                        dctrl.load = 1'b1;
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                dctrl.go   = 1'b1;
                state_next = ST_DRAW;
            end
            ST_DRAW:
            begin
                if (draw_done)
                begin
                    j_next     = i_reg + draw_rem;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SWAP_I;
            end
            ST_SWAP_I:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[IDX_W-1:0];
                wr_data    = rd_b_reg;
                state_next = ST_SWAP_J;
            end
            ST_SWAP_J:
            begin
                wr_en      = 1'b1;
                wr_addr    = j_reg[IDX_W-1:0];
                wr_data    = rd_a_reg;
                dctrl.next = 1'b1;
                if (i_inc == n_reg)
                begin
                    i_next     = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_MIX;
                end
            end
            ST_EMIT:
            begin
                // read issued now, data and strobe land together next cycle
                strobe_next = 1'b1;
                final_next  = (i_inc == n_reg);
                i_next      = i_inc;
                if (i_inc == n_reg)
                begin
                    count_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            strobe_reg <= 1'b0;
            final_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            strobe_reg <= strobe_next;
            final_reg  <= final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign busy               = (state_reg != ST_IDLE);
    assign strobe             = strobe_reg;
    assign result.shuffled_id = rd_a_reg;
    assign result.final_entry = final_reg;

endmodule

FILE: verif/tb_seeded_list_shuffle.sv
`timescale 1ns / 100ps

module tb_seeded_list_shuffle;

    import sls_pkg::*;

    localparam int          STORE_DEPTH  = 32;
    localparam logic [63:0] MIX_FACTOR   = 64'd2685821657736338717;
    localparam int          LIMIT_CYCLES = 2000000;
    localparam int          REPORT_MAX   = 10;
    localparam int          DRAIN_CYCLES = 150;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    strobe;
    result_t result;

    seeded_list_shuffle uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    // predictor copy of the list held by the block
    logic [63:0]  held_ids [STORE_DEPTH];
    int unsigned  held_count;
    result_t      pending_results [$];

    int           fail_count;
    int           reported;
    int unsigned  cycle_count;
    int           idle_pct;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] swap_draw(input logic [63:0] seed_hi,
                                              input int unsigned idx);
        logic [63:0] k;
        k = seed_hi + 64'(idx) * MIX_FACTOR;
        k = k ^ (k >> 12);
        k = k ^ (k << 25);
        k = k ^ (k >> 27);
        return k * MIX_FACTOR;
    endfunction

    // store one beat; on the last one permute the list and queue its results
    function automatic void load_and_shuffle(input item_t it);
        logic [63:0] seed_hi;
        logic [63:0] k;
        logic [63:0] tmp;
        int unsigned span;
        int unsigned j;
        result_t     r;
        if (held_count < STORE_DEPTH)
        begin
            held_ids[held_count] = it.entry_id;
            held_count++;
        end
        if (it.last)
        begin
            seed_hi = {it.seed_seconds, 32'h0};
            for (int unsigned i = 0; i < held_count; i++)
            begin
                k    = swap_draw(seed_hi, i);
                span = held_count - i;
                j    = i + int'(k % 64'(span));
                tmp          = held_ids[i];
                held_ids[i]  = held_ids[j];
                held_ids[j]  = tmp;
            end
            for (int unsigned i = 0; i < held_count; i++)
            begin
                r.shuffled_id = held_ids[i];
                r.final_entry = (i + 1 == held_count);
                pending_results.insert(pending_results.size(), r);
            end
            held_count = 0;
        end
    endfunction

    task automatic flag_failure(input string what);
        fail_count++;
        if (reported < REPORT_MAX)
        begin
            reported++;
            $display("%s", what);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && strobe)
        begin
            if (pending_results.size() == 0)
                flag_failure($sformatf("unexpected result: id %h final %b",
                                       result.shuffled_id, result.final_entry));
            else
            begin
                want = pending_results.pop_front();
                if (result.shuffled_id !== want.shuffled_id)
                    flag_failure($sformatf("shuffled_id mismatch: expected %h got %h",
                                           want.shuffled_id, result.shuffled_id));
                if (result.final_entry !== want.final_entry)
                    flag_failure($sformatf("final_entry mismatch: expected %b got %b",
                                           want.final_entry, result.final_entry));
            end
        end
    end

    function automatic item_t make_item(input logic [63:0] id, input logic [31:0] seed,
                                        input logic is_last);
        item_t it;
        it.entry_id     = id;
        it.seed_seconds = seed;
        it.last         = is_last;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(input item_t it);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            item  <= make_item({$urandom, $urandom}, $urandom, 1'($urandom_range(1)));
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        load_and_shuffle(it);
        @(negedge clk);
    endtask

    task automatic test_single_entry_lists();
        send_item(make_item(64'h0, 32'h0, 1'b1));
        send_item(make_item({64{1'b1}}, {32{1'b1}}, 1'b1));
    endtask

    task automatic test_field_extremes();
        send_item(make_item(64'h0, {32{1'b1}}, 1'b0));
        send_item(make_item({64{1'b1}}, 32'h0, 1'b0));
        send_item(make_item(64'h8000_0000_0000_0000, 32'h5555_5555, 1'b0));
        send_item(make_item(64'h1, {32{1'b1}}, 1'b1));
        send_item(make_item(64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 1'b0));
        send_item(make_item(64'h5555_5555_5555_5555, 32'h0, 1'b0));
        send_item(make_item(64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000, 1'b1));
    endtask

    // 32 entries fill the store; the 33rd is dropped but its seed drives the pass
    task automatic test_full_store_drop();
        for (int e = 0; e < STORE_DEPTH; e++)
            send_item(make_item({$urandom, $urandom}, $urandom, 1'b0));
        send_item(make_item({64{1'b1}}, $urandom, 1'b1));
    endtask

    task automatic test_random_lists(input int pct, input int n_items);
        int    sent;
        int    len;
        int    pick;
        item_t it;
        idle_pct = pct;
        sent     = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                len = $urandom_range(1, 8);
            else if (pick < 90)
                len = $urandom_range(9, STORE_DEPTH);
            else
                len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
            for (int e = 0; e < len; e++)
            begin
                it = make_item({$urandom, $urandom}, $urandom, e == len - 1);
                if (it.last)
                begin
                    pick = $urandom_range(9);
                    if (pick == 0)
                        it.seed_seconds = 32'h0;
                    else if (pick == 1)
                        it.seed_seconds = {32{1'b1}};
                end
                send_item(it);
                sent++;
            end
        end
    endtask

    initial
    begin
        start       = 1'b0;
        item        = '0;
        rst_n       = 1'b0;
        held_count  = 0;
        fail_count  = 0;
        reported    = 0;
        cycle_count = 0;
        idle_pct    = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_entry_lists();
        test_field_extremes();
        test_full_store_drop();
        test_random_lists(0, 70);
        test_random_lists(59, 70);
        test_random_lists(26, 70);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
